### design/mesa_pkg.sv
// ----------------------------------------------------------------------------
// mesa_pkg
// Shared types and constants of the MIPS execute-stage ALU: operation codes,
// forwarding selects and the packed widths of the stream items.
// ----------------------------------------------------------------------------
package mesa_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CMD_W   = 5;
    localparam int unsigned SHAMT_W = 5;
    localparam int unsigned IMM_W   = 16;
    localparam int unsigned FWD_W   = 2;

    // packed item widths, padded to whole bytes
    localparam int unsigned IN_BITS   = CMD_W + 2 * DATA_W + SHAMT_W + IMM_W + FWD_W;
    localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_BITS  = 2 * DATA_W + 2;
    localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // word and half accesses report the address of their last byte
    localparam logic [DATA_W-1:0] WORD_OFFSET = DATA_W'(3);
    localparam logic [DATA_W-1:0] HALF_OFFSET = DATA_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 5'd0,
        CMD_ADDU  = 5'd1,
        CMD_SUB   = 5'd2,
        CMD_AND   = 5'd3,
        CMD_OR    = 5'd4,
        CMD_XOR   = 5'd5,
        CMD_NOR   = 5'd6,
        CMD_NAND  = 5'd7,
        CMD_SLT   = 5'd8,
        CMD_SLL   = 5'd9,
        CMD_SRL   = 5'd10,
        CMD_SRA   = 5'd11,
        CMD_ADDI  = 5'd12,
        CMD_ADDIU = 5'd13,
        CMD_LW    = 5'd14,
        CMD_LH    = 5'd15,
        CMD_LHU   = 5'd16,
        CMD_LB    = 5'd17,
        CMD_LBU   = 5'd18,
        CMD_SW    = 5'd19,
        CMD_SH    = 5'd20,
        CMD_SB    = 5'd21,
        CMD_LUI   = 5'd22,
        CMD_ANDI  = 5'd23,
        CMD_ORI   = 5'd24,
        CMD_NORI  = 5'd25,
        CMD_SLTI  = 5'd26,
        CMD_HALT  = 5'd27
    } t_cmd;

    typedef enum logic [FWD_W-1:0] {
        FWD_NO_HAZARD = 2'd0,
        FWD_TO_RS     = 2'd1,
        FWD_TO_RT     = 2'd2
    } t_fwd;

    typedef struct packed {
        logic [FWD_W-1:0]   fwd;
        logic [IMM_W-1:0]   imm;
        logic [SHAMT_W-1:0] shamt;
        logic [DATA_W-1:0]  rt;
        logic [DATA_W-1:0]  rs;
        logic [CMD_W-1:0]   cmd;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] store_operand;
        logic              overflow_flag;
        logic              write_enable;
        logic [DATA_W-1:0] result_value;
    } t_out_item;

endpackage

### design/mips_execute_stage_alu_unit.sv
// ----------------------------------------------------------------------------
// mips_execute_stage_alu_unit
// Execute stage of a 32-bit MIPS-like pipeline: ALU, address add and operand
// forwarding from the previous result.
// ----------------------------------------------------------------------------
// One instruction enters per clock unless a full input register waits behind
// a blocked output: an input register holds the instruction, the ALU works on
// it combinationally and the result register presents it downstream. The
// previous result, used for forwarding and repeated by HALT or unknown codes,
// is a register loaded in the same cycle as the result register, so the ALU
// plus the forwarding mux form the loop that sets the rate. Both advance when
// the input register is full and the result register is empty or being taken.
module mips_execute_stage_alu_unit
    import mesa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // command, first_operand, second_operand, shift_amount, immediate_bits,
    // forward_select, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // result_value, write_enable, overflow_flag, store_operand, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic              r_in_valid;
    t_in_item          r_in;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [DATA_W-1:0] r_last_result;

    logic              out_free;
    logic              advance;
    t_out_item         n_out;

    logic [DATA_W-1:0] rs;
    logic [DATA_W-1:0] rt;
    logic [DATA_W-1:0] imm_s;
    logic [DATA_W-1:0] imm_z;
    logic [DATA_W-1:0] sum_rr;
    logic [DATA_W-1:0] diff_rr;
    logic [DATA_W-1:0] sum_ri;
    logic              ovf_rr;
    logic              ovf_sub;
    logic              ovf_ri;
    t_cmd              cmd;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    always_comb begin
        rs = r_in.rs;
        rt = r_in.rt;
        if (t_fwd'(r_in.fwd) == FWD_TO_RS) begin
            rs = r_last_result;
        end else if (t_fwd'(r_in.fwd) == FWD_TO_RT) begin
            rt = r_last_result;
        end
    end

    assign imm_s   = {{(DATA_W - IMM_W){r_in.imm[IMM_W-1]}}, r_in.imm};
    assign imm_z   = {{(DATA_W - IMM_W){1'b0}}, r_in.imm};
    assign sum_rr  = rs + rt;
    assign diff_rr = rs - rt;
    assign sum_ri  = rs + imm_s;
    assign ovf_rr  = (rs[DATA_W-1] == rt[DATA_W-1]) && (sum_rr[DATA_W-1] != rs[DATA_W-1]);
    assign ovf_sub = (rs[DATA_W-1] != rt[DATA_W-1]) && (diff_rr[DATA_W-1] != rs[DATA_W-1]);
    assign ovf_ri  = (rs[DATA_W-1] == imm_s[DATA_W-1]) && (sum_ri[DATA_W-1] != rs[DATA_W-1]);
    assign cmd     = t_cmd'(r_in.cmd);

    always_comb begin
        n_out.result_value  = r_last_result;
        n_out.write_enable  = 1'b1;
        n_out.overflow_flag = 1'b0;
        n_out.store_operand = rt;
        case (cmd)
            CMD_ADD: begin
                n_out.result_value  = sum_rr;
                n_out.overflow_flag = ovf_rr;
            end
            CMD_ADDU: n_out.result_value = sum_rr;
            CMD_SUB: begin
                n_out.result_value  = diff_rr;
                n_out.overflow_flag = ovf_sub;
            end
            CMD_AND:  n_out.result_value = rs & rt;
            CMD_OR:   n_out.result_value = rs | rt;
            CMD_XOR:  n_out.result_value = rs ^ rt;
            CMD_NOR:  n_out.result_value = ~(rs | rt);
            CMD_NAND: n_out.result_value = ~(rs & rt);
            CMD_SLT:  n_out.result_value = DATA_W'($signed(rs) < $signed(rt));
            CMD_SLL:  n_out.result_value = rt << r_in.shamt;
            CMD_SRL:  n_out.result_value = rt >> r_in.shamt;
            CMD_SRA:  n_out.result_value = DATA_W'($signed(rt) >>> r_in.shamt);
            CMD_ADDI: begin
                n_out.result_value  = sum_ri;
                n_out.overflow_flag = ovf_ri;
            end
            CMD_ADDIU: n_out.result_value = sum_ri;
            CMD_LW, CMD_LH, CMD_LHU, CMD_LB, CMD_LBU, CMD_SW, CMD_SH, CMD_SB: begin
                n_out.overflow_flag = ovf_ri;
                n_out.write_enable  = !(cmd inside {CMD_SW, CMD_SH, CMD_SB});
                if (cmd inside {CMD_LW, CMD_SW}) begin
                    n_out.result_value = sum_ri + WORD_OFFSET;
                end else if (cmd inside {CMD_LH, CMD_LHU, CMD_SH}) begin
                    n_out.result_value = sum_ri + HALF_OFFSET;
                end else begin
                    n_out.result_value = sum_ri;
                end
            end
            CMD_LUI:  n_out.result_value = {r_in.imm, {(DATA_W - IMM_W){1'b0}}};
            CMD_ANDI: n_out.result_value = rs & imm_z;
            CMD_ORI:  n_out.result_value = rs | imm_z;
            CMD_NORI: n_out.result_value = ~(rs | imm_z);
            CMD_SLTI: n_out.result_value = DATA_W'($signed(rs) < $signed(imm_s));
            // halt and unknown codes repeat the previous result
            default:  n_out.write_enable = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_last_result <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_last_result <= n_out.result_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= i_s_tdata[IN_BITS-1:0];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, r_out};

`ifndef SYNTH
    // the presented result is always the one kept for forwarding
    a_last_matches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.result_value == r_last_result))
        else $error("held result differs from the forwarding register");

    // input side stalls only behind a full input register and a blocked output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input stalled without a blocked output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("pipeline not empty after reset");
`endif

endmodule

### dv/mips_execute_stage_alu_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_execute_stage_alu_unit_tb
// Stream testbench for the execute-stage ALU. A clocked driver feeds decoded
// instructions from a queue and predicts each result when the instruction is
// taken. A clocked monitor compares every result against the oldest
// prediction. Both sides idle at random in the first two of three phases.
// Directed corner cases come first, then random instructions.
// ----------------------------------------------------------------------------
module mips_execute_stage_alu_unit_tb
    import mesa_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned TAIL_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS = 275;
    // codes past HALT are undefined and forward select three is unused
    localparam logic [CMD_W-1:0] CMD_UNDEF_MAX = 5'd31;
    localparam logic [FWD_W-1:0] FWD_UNUSED    = 2'd3;

    typedef struct {
        t_in_item instr;
        bit       drain;   // hold this item back until the pipe is empty
    } t_pending;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    t_in_item               s_item = '0;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    t_pending    instr_q[$];
    t_out_item   result_q[$];
    logic [31:0] prev_result = '0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          err_cnt = 0;
    int unsigned cycle_cnt = 0;
    t_out_item   predicted;
    t_pending    next_p;
    t_out_item   got;
    t_out_item   want;

    assign s_tdata = IN_TDATA_W'(s_item);

    mips_execute_stage_alu_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // result of one instruction given the previous result
    function automatic t_out_item predict_execute(t_in_item it, logic [31:0] prev);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm_s;
        logic [31:0] imm_z;
        logic [31:0] addr;
        t_out_item   r;
        a = it.rs;
        b = it.rt;
        if (it.fwd == FWD_TO_RS) begin
            a = prev;
        end else if (it.fwd == FWD_TO_RT) begin
            b = prev;
        end
        imm_s = {{16{it.imm[15]}}, it.imm};
        imm_z = {16'b0, it.imm};
        r.result_value  = prev;
        r.write_enable  = 1'b1;
        r.overflow_flag = 1'b0;
        r.store_operand = b;
        case (it.cmd)
            CMD_ADD: begin
                r.result_value  = a + b;
                r.overflow_flag = (a[31] == b[31]) && (r.result_value[31] != a[31]);
            end
            CMD_ADDU:  r.result_value = a + b;
            CMD_SUB: begin
                r.result_value  = a - b;
                r.overflow_flag = (a[31] != b[31]) && (r.result_value[31] != a[31]);
            end
            CMD_AND:   r.result_value = a & b;
            CMD_OR:    r.result_value = a | b;
            CMD_XOR:   r.result_value = a ^ b;
            CMD_NOR:   r.result_value = ~(a | b);
            CMD_NAND:  r.result_value = ~(a & b);
            CMD_SLT:   r.result_value = {31'b0, $signed(a) < $signed(b)};
            CMD_SLL:   r.result_value = b << it.shamt;
            CMD_SRL:   r.result_value = b >> it.shamt;
            CMD_SRA:   r.result_value = $signed(b) >>> it.shamt;
            CMD_ADDI: begin
                r.result_value  = a + imm_s;
                r.overflow_flag = (a[31] == imm_s[31]) && (r.result_value[31] != a[31]);
            end
            CMD_ADDIU: r.result_value = a + imm_s;
            CMD_LW, CMD_LH, CMD_LHU, CMD_LB, CMD_LBU, CMD_SW, CMD_SH, CMD_SB: begin
                // overflow looks at the plain sum, before the access offset
                addr = a + imm_s;
                r.overflow_flag = (a[31] == imm_s[31]) && (addr[31] != a[31]);
                if (it.cmd == CMD_LW || it.cmd == CMD_SW) begin
                    r.result_value = addr + WORD_OFFSET;
                end else if (it.cmd == CMD_LH || it.cmd == CMD_LHU || it.cmd == CMD_SH) begin
                    r.result_value = addr + HALF_OFFSET;
                end else begin
                    r.result_value = addr;
                end
                r.write_enable = (it.cmd != CMD_SW && it.cmd != CMD_SH && it.cmd != CMD_SB);
            end
            CMD_LUI:   r.result_value = {it.imm, 16'b0};
            CMD_ANDI:  r.result_value = a & imm_z;
            CMD_ORI:   r.result_value = a | imm_z;
            CMD_NORI:  r.result_value = ~(a | imm_z);
            CMD_SLTI:  r.result_value = {31'b0, $signed(a) < $signed(imm_s)};
            default:   r.write_enable = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hffff_ffff;
            3:       return 32'h7fff_ffff;
            4:       return 32'h8000_0000;
            5:       return 32'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item random_instr();
        t_in_item it;
        int       f;
        if ($urandom_range(19) == 0) begin
            it.cmd = CMD_UNDEF_MAX - CMD_W'($urandom_range(3));
        end else begin
            it.cmd = CMD_W'($urandom_range(CMD_HALT));
        end
        it.rs    = pick_word();
        it.rt    = pick_word();
        it.shamt = SHAMT_W'($urandom);
        case ($urandom_range(5))
            0:       it.imm = 16'h0000;
            1:       it.imm = 16'hffff;
            2:       it.imm = $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: it.imm = IMM_W'($urandom);
        endcase
        f = $urandom_range(9);
        if (f < 4) begin
            it.fwd = FWD_NO_HAZARD;
        end else if (f < 7) begin
            it.fwd = FWD_TO_RS;
        end else if (f < 9) begin
            it.fwd = FWD_TO_RT;
        end else begin
            it.fwd = FWD_UNUSED;
        end
        return it;
    endfunction

    task automatic queue_instr(logic [CMD_W-1:0] cmd, logic [31:0] rs, logic [31:0] rt,
                               logic [SHAMT_W-1:0] sh, logic [IMM_W-1:0] imm,
                               logic [FWD_W-1:0] fwd);
        t_pending p;
        p.instr = '{fwd: fwd, imm: imm, shamt: sh, rt: rt, rs: rs, cmd: cmd};
        p.drain = 1'b0;
        instr_q.push_back(p);
    endtask

    task automatic queue_random(int n, bit drain_first);
        t_pending p;
        for (int i = 0; i < n; i++) begin
            p.instr = random_instr();
            p.drain = (i == 0 && drain_first) || ($urandom_range(99) == 0);
            instr_q.push_back(p);
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // driver: predicts on acceptance, then presents the next item or idles
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted = predict_execute(s_item, prev_result);
                prev_result = predicted.result_value;
                result_q.push_back(predicted);
            end
            if (!s_tvalid || s_tready) begin
                if (instr_q.size() != 0
                        && !(instr_q[0].drain && (result_q.size() != 0 || m_tvalid))
                        && $urandom_range(99) >= send_idle_pct) begin
                    next_p = instr_q.pop_front();
                    s_item   <= next_p.instr;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = t_out_item'(m_tdata[OUT_BITS-1:0]);
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %h", $time, got);
                    err_cnt++;
                end else begin
                    want = result_q.pop_front();
                    check_field("result_value", want.result_value, got.result_value);
                    check_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
                    check_field("overflow_flag", 32'(want.overflow_flag),
                                32'(got.overflow_flag));
                    check_field("store_operand", want.store_operand, got.store_operand);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 26;
        recv_stall_pct = 87;
        queue_instr(CMD_ADD,   32'h7fff_ffff, 32'h0000_0001, 5'd0,  16'h0000, FWD_NO_HAZARD);
        queue_instr(CMD_ADDU,  32'hffff_ffff, 32'h0000_0001, 5'd0,  16'h0000, FWD_NO_HAZARD);
        queue_instr(CMD_SUB,   32'h0000_0000, 32'h8000_0000, 5'd0,  16'h0000, FWD_NO_HAZARD);
        queue_instr(CMD_AND,   32'hffff_ffff, 32'ha5a5_a5a5, 5'd0,  16'h0000, FWD_NO_HAZARD);
        queue_instr(CMD_OR,    32'h0000_0000, 32'h8000_0000, 5'd0,  16'h0000, FWD_TO_RS);
        queue_instr(CMD_XOR,   32'hffff_ffff, 32'h0f0f_0f0f, 5'd0,  16'h0000, FWD_TO_RT);
        queue_instr(CMD_NOR,   32'h0000_0000, 32'h0000_0000, 5'd0,  16'h0000, FWD_NO_HAZARD);
        queue_instr(CMD_NAND,  32'hffff_ffff, 32'hffff_ffff, 5'd0,  16'h0000, FWD_NO_HAZARD);
        queue_instr(CMD_SLT,   32'h8000_0000, 32'h7fff_ffff, 5'd0,  16'h0000, FWD_NO_HAZARD);
        queue_instr(CMD_SLL,   32'h0000_0000, 32'h0000_0001, 5'd31, 16'h0000, FWD_NO_HAZARD);
        queue_instr(CMD_SRL,   32'h0000_0000, 32'h8000_0000, 5'd31, 16'h0000, FWD_NO_HAZARD);
        queue_instr(CMD_SRA,   32'h0000_0000, 32'h8000_0000, 5'd31, 16'h0000, FWD_NO_HAZARD);
        queue_instr(CMD_ADDI,  32'h7fff_ffff, 32'h0000_0000, 5'd0,  16'h0001, FWD_NO_HAZARD);
        queue_instr(CMD_ADDIU, 32'h8000_0000, 32'h0000_0000, 5'd0,  16'hffff, FWD_NO_HAZARD);
        // address wraps to zero through the word offset
        queue_instr(CMD_LW,    32'hffff_ffff, 32'h0000_0000, 5'd0,  16'hfffe, FWD_NO_HAZARD);
        queue_instr(CMD_LH,    32'h7fff_ffff, 32'h0000_0000, 5'd0,  16'h7fff, FWD_NO_HAZARD);
        queue_instr(CMD_LHU,   32'h0000_0000, 32'h0000_0000, 5'd0,  16'h0000, FWD_NO_HAZARD);
        queue_instr(CMD_LB,    32'h8000_0000, 32'h0000_0000, 5'd0,  16'h8000, FWD_NO_HAZARD);
        queue_instr(CMD_LBU,   32'hffff_ffff, 32'h0000_0000, 5'd0,  16'h0001, FWD_NO_HAZARD);
        queue_instr(CMD_SW,    32'h8000_0000, 32'h1234_5678, 5'd0,  16'h8000, FWD_NO_HAZARD);
        queue_instr(CMD_SH,    32'hffff_fffe, 32'hffff_ffff, 5'd0,  16'h0000, FWD_TO_RT);
        queue_instr(CMD_SB,    32'h0000_0000, 32'h8000_0000, 5'd0,  16'h7fff, FWD_TO_RS);
        queue_instr(CMD_LUI,   32'h0000_0000, 32'h0000_0000, 5'd0,  16'hffff, FWD_NO_HAZARD);
        queue_instr(CMD_ANDI,  32'hffff_ffff, 32'h0000_0000, 5'd0,  16'hffff, FWD_NO_HAZARD);
        queue_instr(CMD_ORI,   32'h0000_0000, 32'h0000_0000, 5'd0,  16'h8000, FWD_NO_HAZARD);
        queue_instr(CMD_NORI,  32'h0000_0000, 32'h0000_0000, 5'd0,  16'h0000, FWD_NO_HAZARD);
        queue_instr(CMD_SLTI,  32'hffff_ffff, 32'h0000_0000, 5'd0,  16'h0000, FWD_NO_HAZARD);
        queue_instr(CMD_HALT,  32'h1111_1111, 32'h2222_2222, 5'd7,  16'h3333, FWD_TO_RS);
        queue_instr(CMD_UNDEF_MAX, 32'h4444_4444, 32'h5555_5555, 5'd3, 16'h6666, FWD_TO_RT);
        queue_instr(CMD_ADD,   32'h0000_0005, 32'h0000_0007, 5'd0,  16'h0000, FWD_UNUSED);
        queue_random(PHASE_ITEMS, 1'b0);
        while (instr_q.size() != 0) @(posedge clk);

        send_idle_pct  = 87;
        recv_stall_pct = 26;
        queue_random(PHASE_ITEMS, 1'b1);
        while (instr_q.size() != 0) @(posedge clk);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random(PHASE_ITEMS, 1'b1);
        // sample between edges so the driver and monitor updates have settled
        while (instr_q.size() != 0 || s_tvalid || result_q.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
